// ----- rtl/ptrt_pkg.sv -----
package ptrt_pkg;

  // table geometry
  localparam int FUNC_SLOTS = 8;
  localparam int CMD_SLOTS  = 8;
  localparam int ID_COUNT   = 256;
  localparam int NSLOTS     = FUNC_SLOTS + CMD_SLOTS;
  localparam int SLOT_W     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int MAXRES     = 16;
  localparam int CNT_W      = $clog2(MAXRES + 1);

  localparam logic [15:0] REPS_INF = 16'hFFFF;

  // command codes
  localparam logic [3:0] CMD_SCHED_AT   = 4'd0;
  localparam logic [3:0] CMD_SCHED_IN   = 4'd1;
  localparam logic [3:0] CMD_DESCHED    = 4'd2;
  localparam logic [3:0] CMD_RESCHED_AT = 4'd3;
  localparam logic [3:0] CMD_RESCHED_IN = 4'd4;
  localparam logic [3:0] CMD_UPDATE     = 4'd5;
  localparam logic [3:0] CMD_CLEAR      = 4'd6;
  localparam logic [3:0] CMD_RUN        = 4'd7;
  localparam logic [3:0] CMD_REFRESH    = 4'd8;

  // result kinds
  localparam logic RES_REPLY   = 1'b0;
  localparam logic RES_RELEASE = 1'b1;

  // slot occupancy
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FUNC = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  // controller commands
  typedef struct packed {
    logic latch;
    logic scan;
    logic finish;
  } ctrl_t;

  // datapath status
  typedef struct packed {
    logic scan_last;
  } stat_t;

  // one result word
  typedef struct packed {
    logic       kind;
    logic       status;
    logic [7:0] id;
    logic       rkind;
    logic [3:0] slot;
    logic       persist;
    logic       last;
  } res_t;

  function automatic res_t mk_res(logic kind, logic status, logic [7:0] id, logic rkind,
                                  logic [3:0] slot, logic persist, logic last);
    res_t r;
    r.kind    = kind;
    r.status  = status;
    r.id      = id;
    r.rkind   = rkind;
    r.slot    = slot;
    r.persist = persist;
    r.last    = last;
    return r;
  endfunction

endpackage

// ----- rtl/ptrt_ctrl.sv -----
module ptrt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ptrt_pkg::stat_t stat,
  output ptrt_pkg::ctrl_t ctrl,
  output logic            busy
);

  ptrt_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptrt_pkg::ST_IDLE:   if (start) state_nxt = ptrt_pkg::ST_SCAN;
      ptrt_pkg::ST_SCAN:   if (stat.scan_last) state_nxt = ptrt_pkg::ST_FINISH;
      ptrt_pkg::ST_FINISH: state_nxt = ptrt_pkg::ST_IDLE;
      default:             state_nxt = ptrt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state_r)
      ptrt_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctrl.latch = start;
      end
      ptrt_pkg::ST_SCAN:   ctrl.scan = 1'b1;
      ptrt_pkg::ST_FINISH: ctrl.finish = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ptrt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/ptrt_datapath.sv -----
module ptrt_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  ptrt_pkg::ctrl_t ctrl,
  output ptrt_pkg::stat_t stat,
  input  logic [3:0]      in_command,
  input  logic [7:0]      in_task_id,
  input  logic            in_task_kind,
  input  logic [63:0]     in_when_ms,
  input  logic [63:0]     in_now_ms,
  input  logic [31:0]     in_interval_ms,
  input  logic [15:0]     in_repetitions,
  output logic            out_strobe,
  output ptrt_pkg::res_t  out_res
);

  localparam int SW = ptrt_pkg::SLOT_W;
  localparam int CW = ptrt_pkg::CNT_W;

  // slot table
  logic [7:0]            owner_r  [ptrt_pkg::NSLOTS];
  ptrt_pkg::kind_t       kind_r   [ptrt_pkg::NSLOTS];
  logic                  active_r [ptrt_pkg::NSLOTS];
  logic [63:0]           rel_r    [ptrt_pkg::NSLOTS];
  logic [31:0]           per_r    [ptrt_pkg::NSLOTS];
  logic [15:0]           reps_r   [ptrt_pkg::NSLOTS];

  // latched command word
  logic [3:0]  cmd_r;
  logic [7:0]  id_r;
  logic        tk_r;
  logic [63:0] when_r;
  logic [63:0] now_r;
  logic [31:0] pin_r;
  logic [15:0] rin_r;

  // scan state
  logic [SW-1:0] idx_r;
  logic          hit_v_r, hit_cmd_r, free_v_r;
  logic [SW-1:0] hit_idx_r, free_idx_r;
  logic          pend_v_r, pend_cmd_r;
  logic [7:0]    pend_id_r;
  logic [SW-1:0] pend_idx_r;
  logic [CW-1:0] rel_cnt_r;

  logic           strobe_r;
  ptrt_pkg::res_t res_r;
  ptrt_pkg::res_t fail_res;

  logic is_sched, is_perid, is_run, is_refresh, id_ok;
  ptrt_pkg::kind_t cur_kind;
  logic        occ, cur_act, cur_cmd, due, rel_go, in_seg;
  logic [63:0] cur_rel, diff;
  logic [15:0] cur_reps, reps_dec;
  logic [SW-1:0] apply_idx;
  logic [63:0]   in_time;

  // command classes
  assign is_sched   = (cmd_r == ptrt_pkg::CMD_SCHED_AT) || (cmd_r == ptrt_pkg::CMD_SCHED_IN);
  assign is_perid   = (cmd_r == ptrt_pkg::CMD_DESCHED) || (cmd_r == ptrt_pkg::CMD_RESCHED_AT) ||
                      (cmd_r == ptrt_pkg::CMD_RESCHED_IN) || (cmd_r == ptrt_pkg::CMD_UPDATE) ||
                      (cmd_r == ptrt_pkg::CMD_CLEAR);
  assign is_run     = (cmd_r == ptrt_pkg::CMD_RUN);
  assign is_refresh = (cmd_r == ptrt_pkg::CMD_REFRESH);
  assign id_ok      = ({1'b0, id_r} < 9'(ptrt_pkg::ID_COUNT));

  // failure reply for the latched id
  assign fail_res = ptrt_pkg::mk_res(ptrt_pkg::RES_REPLY, 1'b1, id_r, 1'b0, 4'd0, 1'b0, 1'b1);

  // current scan slot
  assign cur_kind = kind_r[idx_r];
  assign cur_act  = active_r[idx_r];
  assign cur_rel  = rel_r[idx_r];
  assign cur_reps = reps_r[idx_r];
  assign occ      = (cur_kind != ptrt_pkg::KIND_NONE);
  assign cur_cmd  = (cur_kind == ptrt_pkg::KIND_CMD);
  assign diff     = cur_rel - now_r;
  assign due      = diff[63] || (diff == 64'd0);
  assign rel_go   = is_run && occ && cur_act && due && (rel_cnt_r != CW'(ptrt_pkg::MAXRES));
  assign reps_dec = ((cur_reps != 16'd0) && (cur_reps != ptrt_pkg::REPS_INF)) ?
                    cur_reps - 16'd1 : cur_reps;
  assign in_seg   = tk_r ? (idx_r >= SW'(ptrt_pkg::FUNC_SLOTS))
                         : (idx_r <  SW'(ptrt_pkg::FUNC_SLOTS));

  assign stat.scan_last = (idx_r == SW'(ptrt_pkg::NSLOTS - 1));

  // slot written at the end of a command, and the "at" or "in" time
  assign apply_idx = is_sched ? free_idx_r : hit_idx_r;
  assign in_time   = ((cmd_r == ptrt_pkg::CMD_SCHED_AT) || (cmd_r == ptrt_pkg::CMD_RESCHED_AT)) ?
                     when_r : now_r + when_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptrt_pkg::NSLOTS; i++) begin
        kind_r[i]   <= ptrt_pkg::KIND_NONE;
        active_r[i] <= 1'b0;
      end
      strobe_r  <= 1'b0;
      pend_v_r  <= 1'b0;
      hit_v_r   <= 1'b0;
      free_v_r  <= 1'b0;
      rel_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      // a word goes out after each held release and at the finish
      strobe_r <= ctrl.finish || (ctrl.scan && rel_go && pend_v_r);

      // capture command word
      if (ctrl.latch) begin
        cmd_r     <= in_command;
        id_r      <= in_task_id;
        tk_r      <= in_task_kind;
        when_r    <= in_when_ms;
        now_r     <= in_now_ms;
        pin_r     <= in_interval_ms;
        rin_r     <= in_repetitions;
        idx_r     <= '0;
        hit_v_r   <= 1'b0;
        free_v_r  <= 1'b0;
        pend_v_r  <= 1'b0;
        rel_cnt_r <= '0;
      end

      // one slot per cycle
      if (ctrl.scan) begin
        idx_r <= idx_r + 1'b1;
        if (rel_go) begin
          reps_r[idx_r] <= reps_dec;
          if (reps_dec != 16'd0) begin
            rel_r[idx_r] <= now_r + 64'(per_r[idx_r]);
          end else begin
            kind_r[idx_r]   <= ptrt_pkg::KIND_NONE;
            active_r[idx_r] <= 1'b0;
          end
          // previous release goes out, this one waits for its last flag
          if (pend_v_r) begin
            res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_RELEASE, 1'b0, pend_id_r, pend_cmd_r,
                                      4'(pend_idx_r), pend_cmd_r, 1'b0);
          end
          pend_v_r   <= 1'b1;
          pend_id_r  <= owner_r[idx_r];
          pend_cmd_r <= cur_cmd;
          pend_idx_r <= idx_r;
          rel_cnt_r  <= rel_cnt_r + 1'b1;
        end
        if (is_refresh && cur_act) begin
          rel_r[idx_r] <= now_r + cur_rel - when_r;
        end
        if ((is_sched || is_perid) && occ && (owner_r[idx_r] == id_r)) begin
          hit_v_r   <= 1'b1;
          hit_idx_r <= idx_r;
          hit_cmd_r <= cur_cmd;
        end
        if (is_sched && !occ && in_seg && !free_v_r) begin
          free_v_r   <= 1'b1;
          free_idx_r <= idx_r;
        end
      end

      // apply and reply
      if (ctrl.finish) begin
        if (is_sched) begin
          if (id_ok && !hit_v_r && free_v_r) begin
            owner_r[apply_idx]  <= id_r;
            kind_r[apply_idx]   <= tk_r ? ptrt_pkg::KIND_CMD : ptrt_pkg::KIND_FUNC;
            active_r[apply_idx] <= 1'b1;
            rel_r[apply_idx]    <= in_time;
            per_r[apply_idx]    <= pin_r;
            reps_r[apply_idx]   <= rin_r;
            res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_REPLY, 1'b0, id_r, tk_r, 4'(apply_idx),
                                      tk_r, 1'b1);
          end else begin
            res_r <= fail_res;
          end
        end else if (is_perid) begin
          if (id_ok && hit_v_r) begin
            case (cmd_r)
              ptrt_pkg::CMD_DESCHED: active_r[apply_idx] <= 1'b0;
              ptrt_pkg::CMD_RESCHED_AT, ptrt_pkg::CMD_RESCHED_IN: begin
                active_r[apply_idx] <= 1'b1;
                rel_r[apply_idx]    <= in_time;
              end
              ptrt_pkg::CMD_UPDATE: begin
                per_r[apply_idx]  <= pin_r;
                reps_r[apply_idx] <= rin_r;
              end
              ptrt_pkg::CMD_CLEAR: begin
                kind_r[apply_idx]   <= ptrt_pkg::KIND_NONE;
                active_r[apply_idx] <= 1'b0;
              end
              default: active_r[apply_idx] <= active_r[apply_idx];
            endcase
            res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_REPLY, 1'b0, id_r, hit_cmd_r,
                                      4'(apply_idx), hit_cmd_r, 1'b1);
          end else begin
            res_r <= fail_res;
          end
        end else if (is_run) begin
          if (pend_v_r) begin
            res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_RELEASE, 1'b0, pend_id_r, pend_cmd_r,
                                      4'(pend_idx_r), pend_cmd_r, 1'b1);
          end else begin
            res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_REPLY, 1'b0, 8'd0, 1'b0, 4'd0, 1'b0, 1'b1);
          end
        end else if (is_refresh) begin
          res_r <= ptrt_pkg::mk_res(ptrt_pkg::RES_REPLY, 1'b0, 8'd0, 1'b0, 4'd0, 1'b0, 1'b1);
        end else begin
          res_r <= fail_res;
        end
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

`ifndef SYNTH
  // a held release only exists while the latched command is a run
  a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> is_run) else $error("pending release outside run");

  // every command ends with a final word
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> strobe_r && res_r.last) else $error("missing last word");

  // release words never report failure
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_r.kind) |-> !res_r.status) else $error("failed release");

  // release cap per run
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rel_cnt_r <= CW'(ptrt_pkg::MAXRES)) else $error("release count over cap");
`endif

endmodule

// ----- rtl/periodic_task_release_table.sv -----
// Periodic task release table.
// A command word (in_* ports) is taken at a rising edge with start high and
// busy low. Commands schedule, deschedule, reschedule, update, clear, run and
// refresh tasks held in a table of function slots and command slots.
// Each command scans every slot once, one slot per cycle, then finishes in
// a finish state; busy stays high from the accepting edge through the scan
// and the finish, so the next command is taken once busy is low again at
// the earliest.
// Results appear on out_* for one cycle each, marked by out_strobe; out_last
// flags the final word of a command. The final word is strobed in the first
// cycle with busy low again.
// Every command but a run gives one status word. A run gives one release
// word per due task (up to 16), the earlier ones during the scan, the final
// one after it; with nothing due it gives a single success word.
// The receiver cannot stall: every word must be taken when strobed.
// Reset (rst_n low, synchronous) empties all slots; no clearing pass is needed.
module periodic_task_release_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [7:0]  in_task_id,
  input  logic        in_task_kind,
  input  logic [63:0] in_when_ms,
  input  logic [63:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic [15:0] in_repetitions,
  output logic        out_strobe,
  output logic        out_result_kind,
  output logic        out_status,
  output logic [7:0]  out_released_id,
  output logic        out_released_kind,
  output logic [3:0]  out_slot,
  output logic        out_persist_request,
  output logic        out_last
);

  ptrt_pkg::ctrl_t ctrl;
  ptrt_pkg::stat_t stat;
  ptrt_pkg::res_t  res;

  ptrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ptrt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (in_command),
    .in_task_id     (in_task_id),
    .in_task_kind   (in_task_kind),
    .in_when_ms     (in_when_ms),
    .in_now_ms      (in_now_ms),
    .in_interval_ms (in_interval_ms),
    .in_repetitions (in_repetitions),
    .out_strobe     (out_strobe),
    .out_res        (res)
  );

  assign out_result_kind     = res.kind;
  assign out_status          = res.status;
  assign out_released_id     = res.id;
  assign out_released_kind   = res.rkind;
  assign out_slot            = res.slot;
  assign out_persist_request = res.persist;
  assign out_last            = res.last;

endmodule
